@@ hw/rtl/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// shared constants and status codes for the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

    // default coefficient and fraction widths
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // width of each root word, fixed by the result format
    localparam int ROOT_WIDTH = 33;

    typedef enum logic [1:0] {
        ST_TWO_ROOTS  = 2'd0,
        ST_DOUBLE     = 2'd1,
        ST_NEG_DISC   = 2'd2,
        ST_QUAD_ZERO  = 2'd3
    } status_t;

endpackage

@@ hw/rtl/qrs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// one digit of a pipelined digit-by-digit square root, with sideband payload
// ----------------------------------------------------------------------------
module qrs_sqrt_cell #(
    parameter int W    = 33,
    parameter int RADW = 66,
    parameter int PW   = 34
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [W:0]      in_rem,
    input  logic [W-1:0]    in_root,
    input  logic [RADW-1:0] in_rad,
    input  logic [PW-1:0]   in_pay,
    output logic            out_valid,
    output logic [W:0]      out_rem,
    output logic [W-1:0]    out_root,
    output logic [RADW-1:0] out_rad,
    output logic [PW-1:0]   out_pay
);

    logic [W+2:0]    rem_sh;
    logic [W+2:0]    trial;
    logic [W+3:0]    diff;
    logic            take;
    logic            valid_reg;
    logic [W:0]      rem_reg,  rem_next;
    logic [W-1:0]    root_reg, root_next;
    logic [RADW-1:0] rad_reg;
    logic [PW-1:0]   pay_reg;

    always_comb
    begin
        rem_sh    = {in_rem, in_rad[RADW-1 -: 2]};
        trial     = {1'b0, in_root, 2'b01};
        diff      = {1'b0, rem_sh} - {1'b0, trial};
        take      = ~diff[W+3];
        rem_next  = take ? diff[W:0] : rem_sh[W:0];
        root_next = {in_root[W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        rad_reg  <= {in_rad[RADW-3:0], 2'b00};
        pay_reg  <= in_pay;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;
    assign out_pay   = pay_reg;

endmodule

@@ hw/rtl/qrs_div_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_div_cell
// one quotient bit of two restoring dividers sharing a divisor
// ----------------------------------------------------------------------------
module qrs_div_cell #(
    parameter int DENW = 17,
    parameter int NQW  = 34,
    parameter int PW   = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [DENW-1:0] in_den,
    input  logic [DENW-1:0] in_pr_p,
    input  logic [NQW-1:0]  in_nq_p,
    input  logic [DENW-1:0] in_pr_m,
    input  logic [NQW-1:0]  in_nq_m,
    input  logic [PW-1:0]   in_pay,
    output logic            out_valid,
    output logic [DENW-1:0] out_den,
    output logic [DENW-1:0] out_pr_p,
    output logic [NQW-1:0]  out_nq_p,
    output logic [DENW-1:0] out_pr_m,
    output logic [NQW-1:0]  out_nq_m,
    output logic [PW-1:0]   out_pay
);

    // partial remainder step: shift in one numerator bit, try the divisor
    function automatic logic [DENW+NQW-1:0] div_step(
        input logic [DENW-1:0] pr,
        input logic [NQW-1:0]  nq,
        input logic [DENW-1:0] den
    );
        logic [DENW:0]   t;
        logic [DENW+1:0] d;
        logic            take;
        t    = {pr, nq[NQW-1]};
        d    = {1'b0, t} - {2'b00, den};
        take = ~d[DENW+1];
        div_step = {(take ? d[DENW-1:0] : t[DENW-1:0]), nq[NQW-2:0], take};
    endfunction

    logic                 valid_reg;
    logic [DENW-1:0]      den_reg;
    logic [DENW-1:0]      pr_p_reg, pr_m_reg;
    logic [NQW-1:0]       nq_p_reg, nq_m_reg;
    logic [PW-1:0]        pay_reg;
    logic [DENW+NQW-1:0]  step_p_next, step_m_next;

    always_comb
    begin
        step_p_next = div_step(in_pr_p, in_nq_p, in_den);
        step_m_next = div_step(in_pr_m, in_nq_m, in_den);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= in_den;
        pr_p_reg <= step_p_next[DENW+NQW-1 -: DENW];
        nq_p_reg <= step_p_next[NQW-1:0];
        pr_m_reg <= step_m_next[DENW+NQW-1 -: DENW];
        nq_m_reg <= step_m_next[NQW-1:0];
        pay_reg  <= in_pay;
    end

    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_pr_p  = pr_p_reg;
    assign out_nq_p  = nq_p_reg;
    assign out_pr_m  = pr_m_reg;
    assign out_nq_m  = nq_m_reg;
    assign out_pay   = pay_reg;

endmodule

@@ hw/rtl/quadratic_root_solver_core.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// pipelined solver for a*x^2 + b*x + c = 0 giving fixed-point real roots
// ----------------------------------------------------------------------------
//  channel   handshake      payload
//  input     start / busy   coef_quad, coef_lin, coef_const
//  result    done (strobe)  status, root_plus, root_minus
//
//  a word is taken on every cycle with start high; busy is held low
//  SP = COEF_WIDTH + 1 + FRAC_BITS (33 by default); a word passes the product
//  and discriminant registers, the square root chain (one cell per root bit),
//  the numerator register and the divider chain (one cell per quotient bit)
//  the result word is shown for one cycle with done; the receiver cannot stall
//  reset clears only the valid flags along the chain
// ----------------------------------------------------------------------------
module quadratic_root_solver_core #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COEF_WIDTH-1:0]        coef_quad,
    input  logic signed [COEF_WIDTH-1:0]        coef_lin,
    input  logic signed [COEF_WIDTH-1:0]        coef_const,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_plus,
    output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_minus
);

    import qrs_pkg::*;

    localparam int CW   = COEF_WIDTH;
    localparam int SP   = CW + 1 + FRAC_BITS;        // root bits
    localparam int DW   = 2 * CW + 2;                // signed discriminant
    localparam int DU   = 2 * CW + 1;                // discriminant magnitude
    localparam int RADW = 2 * SP;                    // scaled radicand
    localparam int SPW  = 2 + 2 * CW;                // status, a, b
    localparam int NS   = SP + 2;                    // signed numerator
    localparam int NQW  = SP + 1;                    // numerator magnitude
    localparam int DENW = CW + 1;                    // |2a|
    localparam int RW   = ROOT_WIDTH;
    localparam int MW   = (NQW > RW ? NQW : RW) + 1; // saturation compare width

    // ---------------- stage 1: products ----------------
    logic                      s1_valid_reg;
    logic signed [2*CW-1:0]    bb_reg, ac_reg;
    logic signed [CW-1:0]      s1_a_reg, s1_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        bb_reg   <= coef_lin * coef_lin;
        ac_reg   <= coef_quad * coef_const;
        s1_a_reg <= coef_quad;
        s1_b_reg <= coef_lin;
    end

    // ---------------- stage 2: discriminant and status ----------------
    logic signed [DW-1:0] d_next;
    status_t              st_next;
    logic                 s2_valid_reg;
    logic [DW-1:0]        d_reg;
    logic [SPW-1:0]       s2_pay_reg;

    always_comb
    begin
        // b*b is never negative, 4*a*c fits the wider word exactly
        d_next = {2'b00, bb_reg} - {ac_reg, 2'b00};
        if (s1_a_reg == '0)
            st_next = ST_QUAD_ZERO;
        else if (d_next[DW-1])
            st_next = ST_NEG_DISC;
        else if (d_next == '0)
            st_next = ST_DOUBLE;
        else
            st_next = ST_TWO_ROOTS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        s2_pay_reg <= {st_next, s1_a_reg, s1_b_reg};
    end

    // ---------------- square root chain ----------------
    // radicand is D * 2^(2*FRAC_BITS); each cell consumes its top two bits
    logic            sq_valid [0:SP];
    logic [SP:0]     sq_rem   [0:SP];
    logic [SP-1:0]   sq_root  [0:SP];
    logic [RADW-1:0] sq_rad   [0:SP];
    logic [SPW-1:0]  sq_pay   [0:SP];

    assign sq_valid[0] = s2_valid_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_rad[0]   = {1'b0, d_reg[DU-1:0], {(2*FRAC_BITS){1'b0}}};
    assign sq_pay[0]   = s2_pay_reg;

    for (genvar k = 0; k < SP; k++)
    begin : g_sqrt
        qrs_sqrt_cell #(
            .W    (SP),
            .RADW (RADW),
            .PW   (SPW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[k]),
            .in_rem    (sq_rem[k]),
            .in_root   (sq_root[k]),
            .in_rad    (sq_rad[k]),
            .in_pay    (sq_pay[k]),
            .out_valid (sq_valid[k+1]),
            .out_rem   (sq_rem[k+1]),
            .out_root  (sq_root[k+1]),
            .out_rad   (sq_rad[k+1]),
            .out_pay   (sq_pay[k+1])
        );
    end

    // ---------------- numerators, signs and divisor ----------------
    logic [1:0]           sq_st;
    logic signed [CW-1:0] sq_a, sq_b;
    logic signed [NS-1:0] nb, sx, num_p, num_m, abs_p, abs_m;
    logic [CW:0]          a_ext, a_abs;
    logic                 n_valid_reg;
    logic [DENW-1:0]      den_reg;
    logic [NQW-1:0]       mag_p_reg, mag_m_reg;
    logic [3:0]           n_pay_reg;

    always_comb
    begin
        sq_st = sq_pay[SP][SPW-1 -: 2];
        sq_a  = sq_pay[SP][2*CW-1 -: CW];
        sq_b  = sq_pay[SP][CW-1:0];
        // -b scaled to fixed point
        nb    = '0 - ({{(NS-CW){sq_b[CW-1]}}, sq_b} <<< FRAC_BITS);
        sx    = {2'b00, sq_root[SP]};
        num_p = nb + sx;
        num_m = nb - sx;
        abs_p = num_p[NS-1] ? ('0 - num_p) : num_p;
        abs_m = num_m[NS-1] ? ('0 - num_m) : num_m;
        a_ext = {sq_a[CW-1], sq_a};
        a_abs = a_ext[CW] ? ('0 - a_ext) : a_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else
        begin
            n_valid_reg <= sq_valid[SP];
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg   <= {a_abs[CW-1:0], 1'b0};
        mag_p_reg <= abs_p[NQW-1:0];
        mag_m_reg <= abs_m[NQW-1:0];
        // quotient sign is numerator sign xor divisor sign
        n_pay_reg <= {sq_st, num_p[NS-1] ^ sq_a[CW-1], num_m[NS-1] ^ sq_a[CW-1]};
    end

    // ---------------- divider chain ----------------
    logic            dv_valid [0:NQW];
    logic [DENW-1:0] dv_den   [0:NQW];
    logic [DENW-1:0] dv_pr_p  [0:NQW];
    logic [NQW-1:0]  dv_nq_p  [0:NQW];
    logic [DENW-1:0] dv_pr_m  [0:NQW];
    logic [NQW-1:0]  dv_nq_m  [0:NQW];
    logic [3:0]      dv_pay   [0:NQW];

    assign dv_valid[0] = n_valid_reg;
    assign dv_den[0]   = den_reg;
    assign dv_pr_p[0]  = '0;
    assign dv_nq_p[0]  = mag_p_reg;
    assign dv_pr_m[0]  = '0;
    assign dv_nq_m[0]  = mag_m_reg;
    assign dv_pay[0]   = n_pay_reg;

    for (genvar k = 0; k < NQW; k++)
    begin : g_div
        qrs_div_cell #(
            .DENW (DENW),
            .NQW  (NQW),
            .PW   (4)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[k]),
            .in_den    (dv_den[k]),
            .in_pr_p   (dv_pr_p[k]),
            .in_nq_p   (dv_nq_p[k]),
            .in_pr_m   (dv_pr_m[k]),
            .in_nq_m   (dv_nq_m[k]),
            .in_pay    (dv_pay[k]),
            .out_valid (dv_valid[k+1]),
            .out_den   (dv_den[k+1]),
            .out_pr_p  (dv_pr_p[k+1]),
            .out_nq_p  (dv_nq_p[k+1]),
            .out_pr_m  (dv_pr_m[k+1]),
            .out_nq_m  (dv_nq_m[k+1]),
            .out_pay   (dv_pay[k+1])
        );
    end

    // ---------------- sign, saturation and output word ----------------
    localparam logic [MW-1:0] POS_LIM = (MW'(1) << (RW - 1)) - MW'(1);
    localparam logic [MW-1:0] NEG_LIM = MW'(1) << (RW - 1);

    // apply the sign to a quotient magnitude and clamp to the root range
    function automatic logic [RW-1:0] pack_root(
        input logic [NQW-1:0] mag,
        input logic           neg
    );
        logic [MW-1:0] m;
        logic [MW-1:0] n;
        m = {{(MW-NQW){1'b0}}, mag};
        n = '0 - m;
        if (neg)
            pack_root = (m > NEG_LIM) ? NEG_LIM[RW-1:0] : n[RW-1:0];
        else
            pack_root = (m > POS_LIM) ? POS_LIM[RW-1:0] : m[RW-1:0];
    endfunction

    logic            has_roots;
    logic            done_reg;
    logic [1:0]      status_reg;
    logic [RW-1:0]   root_plus_reg, root_minus_reg;

    // no roots for a zero leading coefficient or a negative discriminant
    assign has_roots = (dv_pay[NQW][3:2] == ST_TWO_ROOTS) ||
                       (dv_pay[NQW][3:2] == ST_DOUBLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[NQW];
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= dv_pay[NQW][3:2];
        root_plus_reg  <= has_roots ? pack_root(dv_nq_p[NQW], dv_pay[NQW][1]) : '0;
        root_minus_reg <= has_roots ? pack_root(dv_nq_m[NQW], dv_pay[NQW][0]) : '0;
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign status     = status_reg;
    assign root_plus  = root_plus_reg;
    assign root_minus = root_minus_reg;

endmodule

@@ bench/quadratic_root_solver_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core_tb
// self-checking bench: coefficient words are driven through start/busy, each
// expected status and root pair is worked out locally and compared in order
// with the words that come out under done
// ----------------------------------------------------------------------------
module quadratic_root_solver_core_tb;
    import qrs_pkg::*;

    localparam int CW      = 16;
    localparam int FB      = 16;
    localparam int PAIRS   = CW + 1 + FB;
    localparam int LATENCY = 2 * PAIRS + 5;
    localparam int LIMIT   = 400000;

    // one expected result word
    typedef struct {
        status_t                        st;
        logic signed [ROOT_WIDTH-1:0]   rp;
        logic signed [ROOT_WIDTH-1:0]   rm;
    } root_word_t;

    // keeps the roots still owed by the pipeline, oldest first
    class root_scoreboard;
        root_word_t pending[$];
        int         mismatches = 0;

        // floor(sqrt(d * 2^(2*FB))), digit by digit
        function automatic longint unsigned fixed_sqrt(longint unsigned d);
            longint unsigned rem, root, pr, trial;
            rem = 0;
            root = 0;
            for (int i = PAIRS - 1; i >= 0; i--)
            begin
                pr = (i >= FB) ? ((d >> (2 * (i - FB))) & 3) : 0;
                rem = (rem << 2) | pr;
                trial = (root << 2) | 1;
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    root = (root << 1) | 1;
                end
                else
                    root = root << 1;
            end
            return root;
        endfunction

        function automatic logic signed [ROOT_WIDTH-1:0] clip_div(longint n, longint den);
            longint q, hi;
            q = n / den;
            hi = (longint'(1) << (ROOT_WIDTH - 1)) - 1;
            if (q > hi)
                q = hi;
            if (q < -hi - 1)
                q = -hi - 1;
            return q[ROOT_WIDTH-1:0];
        endfunction

        function void note_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                 logic signed [CW-1:0] c);
            root_word_t w;
            longint     av, bv, cv, disc, s, nb;
            av = a;
            bv = b;
            cv = c;
            w.st = ST_QUAD_ZERO;
            w.rp = '0;
            w.rm = '0;
            if (av != 0)
            begin
                disc = bv * bv - 4 * av * cv;
                if (disc < 0)
                    w.st = ST_NEG_DISC;
                else
                begin
                    w.st = (disc == 0) ? ST_DOUBLE : ST_TWO_ROOTS;
                    s = longint'(fixed_sqrt(longint'(disc)));
                    nb = -bv * (longint'(1) << FB);
                    w.rp = clip_div(nb + s, 2 * av);
                    w.rm = clip_div(nb - s, 2 * av);
                end
            end
            pending.push_back(w);
        endfunction

        function void check_word(logic [1:0] st, logic signed [ROOT_WIDTH-1:0] rp,
                                 logic signed [ROOT_WIDTH-1:0] rm);
            root_word_t w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: status %0d roots %0d %0d", st, rp, rm);
                return;
            end
            w = pending.pop_front();
            if (st !== w.st || rp !== w.rp || rm !== w.rm)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word differs: exp %0d %0d %0d got %0d %0d %0d",
                             w.st, w.rp, w.rm, st, rp, rm);
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [CW-1:0]          coef_quad;
    logic signed [CW-1:0]          coef_lin;
    logic signed [CW-1:0]          coef_const;
    logic                          done;
    logic [1:0]                    status;
    logic signed [ROOT_WIDTH-1:0]  root_plus;
    logic signed [ROOT_WIDTH-1:0]  root_minus;

    root_scoreboard roots = new();
    int             idle_pct = 0;
    int             cycles = 0;

    quadratic_root_solver_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .coef_quad  (coef_quad),
        .coef_lin   (coef_lin),
        .coef_const (coef_const),
        .done       (done),
        .status     (status),
        .root_plus  (root_plus),
        .root_minus (root_minus)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // results cannot be held off, so every done edge is checked at once
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            roots.check_word(status, root_plus, root_minus);
        if (cycles > LIMIT)
        begin
            $display("quadratic_root_solver_core: mismatch");
            $finish;
        end
    end

    // offer one word at the falling edge, hold it until taken; start stays
    // high into the next word so it is never lowered and raised in one step
    task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                              logic signed [CW-1:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        coef_quad  <= a;
        coef_lin   <= b;
        coef_const <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        roots.note_coefs(a, b, c);
        @(negedge clk);
    endtask

    // often a pick from a small range so that real roots are common, else an extreme or a random word
    function automatic logic signed [CW-1:0] pick_coef();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return CW'($signed($urandom_range(40)) - 20);
        if (r == 4)
            return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        return CW'($urandom());
    endfunction

    // well-formed double roots: a*(x-k)^2 scaled so all fit in range
    task automatic send_square();
        int a, k;
        a = $signed($urandom_range(20)) - 10;
        if (a == 0)
            a = 1;
        k = $signed($urandom_range(40)) - 20;
        send_coefs(CW'(a), CW'(-2 * a * k), CW'(a * k * k));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (roots.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        start      = 1'b0;
        coef_quad  = '0;
        coef_lin   = '0;
        coef_const = '0;
        rst_n      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed words: extremes, every status, double roots
        send_coefs(0, 5, 7);
        send_coefs(16'sh8000, 16'sh8000, 16'sh7fff);
        send_coefs(16'sh7fff, 16'sh7fff, 16'sh8000);
        send_coefs(16'sh8000, 16'sh7fff, 16'sh8000);
        send_coefs(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_coefs(1, 0, 1);
        send_coefs(1, -2, 1);
        send_coefs(4, 4, 1);
        send_coefs(-3, 0, 0);
        send_coefs(1, 0, -2);
        send_coefs(2, -3, 1);
        send_coefs(-1, 16'sh8000, 16'sh7fff);
        send_coefs(1, 16'sh7fff, 0);
        send_coefs(16'shffff, 16'shffff, 16'shffff);
        send_coefs(1, 1, 0);
        send_coefs(3, 1, 0);
        send_coefs(-7, 7, 2);

        // sender pauses until the pipeline is empty
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 83 : (ph == 3) ? 37 : 0;
            for (int n = 0; n < 235; n++)
            begin
                if ($urandom_range(3) == 0)
                    send_square();
                else
                    send_coefs(pick_coef(), pick_coef(), pick_coef());
            end
        end

        drain();
        repeat (LATENCY + 10) @(negedge clk);
        if (roots.mismatches == 0 && roots.pending.size() == 0)
            $display("quadratic_root_solver_core: match");
        else
            $display("quadratic_root_solver_core: mismatch");
        $finish;
    end
endmodule
